>>> rtl/aea_pkg.sv
// Package: shared types, constants and the power table for auto exposure adaptation.
package aea_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_EV_FLOOR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EV_CEILING = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_BRT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_DRK   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EV_COMP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_EN    = 3'd5;

    localparam logic [31:0] Q30_ONE   = 32'h4000_0000;
    localparam logic [20:0] LOG2E_Q20 = 21'd1512775;
    localparam int          POW_DEPTH = 24;

    typedef struct packed {
        logic signed [15:0] ev_floor;
        logic signed [15:0] ev_ceiling;
        logic        [15:0] rate_brighten;
        logic        [15:0] rate_darken;
        logic signed [15:0] ev_compensation;
        logic               auto_enable;
    } t_cfg;

    typedef logic [31:0] t_pow_tab [POW_DEPTH];

    function automatic logic [63:0] f_isqrt(input logic [63:0] v);
        logic [63:0] x;
        logic [63:0] res;
        logic [63:0] bit_w;
        x     = v;
        res   = '0;
        bit_w = 64'h4000_0000_0000_0000;
        for (int k = 0; k < 32; k++) begin
            if (bit_w > x) begin
                bit_w = bit_w >> 2;
            end
        end
        for (int k = 0; k < 32; k++) begin
            if (bit_w != 64'd0) begin
                if (x >= res + bit_w) begin
                    x   = x - (res + bit_w);
                    res = (res >> 1) + bit_w;
                end else begin
                    res = res >> 1;
                end
                bit_w = bit_w >> 2;
            end
        end
        return res;
    endfunction

    // T[i] = 2^(2^-i) in Q2.30
    function automatic t_pow_tab f_pow_tab();
        t_pow_tab tab;
        tab[0] = 32'h8000_0000;
        for (int i = 1; i < POW_DEPTH; i++) begin
            tab[i] = 32'(f_isqrt(64'(tab[i-1]) << 30));
        end
        return tab;
    endfunction

    localparam t_pow_tab POW_TAB = f_pow_tab();

endpackage

>>> rtl/aea_in_if.sv
// Interface: input channel carrying luminance and frame time words.
interface aea_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] avg_luminance;
    logic [15:0] frame_time;

    modport source (output valid, output avg_luminance, output frame_time, input ready);
    modport sink   (input valid, input avg_luminance, input frame_time, output ready);
endinterface

>>> rtl/aea_out_if.sv
// Interface: output channel carrying adapted EV and exposure gain words.
interface aea_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] adapted_ev;
    logic        [31:0] exposure_gain;

    modport source (output valid, output adapted_ev, output exposure_gain, input ready);
    modport sink   (input valid, input adapted_ev, input exposure_gain, output ready);
endinterface

>>> rtl/aea_cfg_if.sv
// Interface: configuration write channel.
interface aea_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/aea_mul.sv
// Shared 32x32 unsigned multiplier used by the log2, rate, log2(e), exp and EV step states of the sequencer.
module aea_mul (
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_p
);
    assign o_p = 64'(i_a) * 64'(i_b);
endmodule

>>> rtl/aea_cfg.sv
// Configuration register file with index decode.
module aea_cfg
    import aea_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    aea_cfg_if.sink i_cfg,
    output t_cfg   o_cfg
);
    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ev_floor        <= -16'sd8192;
            r_cfg.ev_ceiling      <= 16'sd16384;
            r_cfg.rate_brighten   <= 16'd256;
            r_cfg.rate_darken     <= 16'd256;
            r_cfg.ev_compensation <= 16'sd0;
            r_cfg.auto_enable     <= 1'b1;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_EV_FLOOR:   r_cfg.ev_floor        <= $signed(i_cfg.data);
                CFG_EV_CEILING: r_cfg.ev_ceiling      <= $signed(i_cfg.data);
                CFG_RATE_BRT:   r_cfg.rate_brighten   <= i_cfg.data;
                CFG_RATE_DRK:   r_cfg.rate_darken     <= i_cfg.data;
                CFG_EV_COMP:    r_cfg.ev_compensation <= $signed(i_cfg.data);
                CFG_AUTO_EN:    r_cfg.auto_enable     <= i_cfg.data[0];
                default: ;
            endcase
        end
    end
endmodule

>>> rtl/auto_exposure_adaptation.sv
// Top level: auto exposure eye adaptation sequencer around one shared multiplier.
//
// Usage
//   i_in  : one word per frame (avg_luminance Q16.16, frame_time Q4.12).
//   o_out : one word per input (adapted_ev Q5.10 signed, exposure_gain Q16.16).
//   i_cfg : register writes, always ready; write only while the block is idle.
// Timing
//   One item at a time. i_in.ready is high only in the idle state.
//   log2 takes EV_FRAC_BITS squarings, exp(-x) takes 20 multiplies, the gain
//   exp2 takes EV_FRAC_BITS multiplies, all on the one 32x32 multiplier.
//   The first frame skips the adaptation steps, and exp(-x) is skipped when
//   the adaptation exponent has no fraction or underflows.
// Reset
//   Registers take their defaults, current EV is 0 and the next frame snaps
//   the EV straight to its target.
// Stall
//   The result sits in an output register; a new word may be accepted while
//   it waits, and the sequencer holds in its final step until the result
//   register is free.
module auto_exposure_adaptation
    import aea_pkg::*;
#(
    parameter int EV_FRAC_BITS  = 10,
    parameter int LUM_FRAC_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    aea_in_if.sink    i_in,
    aea_out_if.source o_out,
    aea_cfg_if.sink   i_cfg
);
    localparam int          LFLOOR_RAW = ((1 << LUM_FRAC_BITS) + 5000) / 10000;
    localparam logic [31:0] LFLOOR     = (LFLOOR_RAW == 0) ? 32'd1 : 32'(LFLOOR_RAW);
    localparam logic [4:0]  EXP_LEN    = 5'd20;
    localparam logic [4:0]  EVF_LEN    = 5'(EV_FRAC_BITS);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_LOG   = 10'b00_0000_0010,
        S_CLAMP = 10'b00_0000_0100,
        S_RATE  = 10'b00_0000_1000,
        S_LOGE  = 10'b00_0001_0000,
        S_EXP   = 10'b00_0010_0000,
        S_KCALC = 10'b00_0100_0000,
        S_STEP  = 10'b00_1000_0000,
        S_GSET  = 10'b01_0000_0000,
        S_GOUT  = 10'b10_0000_0000
    } t_state;

    t_cfg w_cfg;

    aea_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    // sequencer state
    t_state                    r_state;
    logic [31:0]               r_m;        // log2 mantissa, then exp2 accumulator
    logic [4:0]                r_p;
    logic [EV_FRAC_BITS-1:0]   r_frac;
    logic [4:0]                r_cnt;
    logic [4:0]                r_len;
    logic                      r_gain_ph;
    logic signed [15:0]        r_target;
    logic signed [15:0]        r_cur;
    logic                      r_first;
    logic [15:0]               r_dt;
    logic [31:0]               r_x;
    logic [19:0]               r_g;        // exponent fraction bits, MSB first
    logic [4:0]                r_sh;
    logic [30:0]               r_k;
    logic signed [16:0]        r_ge;
    logic signed [15:0]        r_out_ev;
    logic [31:0]               r_out_gain;
    logic                      r_out_valid;

    // shared multiplier
    logic [31:0] w_ma;
    logic [31:0] w_mb;
    logic [63:0] w_prod;

    aea_mul u_mul (
        .i_a (w_ma),
        .i_b (w_mb),
        .o_p (w_prod)
    );

    // input normalize
    logic [31:0] w_lf;
    logic [4:0]  w_p;
    logic [31:0] w_m0;

    always_comb begin
        w_lf = (i_in.avg_luminance < LFLOOR) ? LFLOOR : i_in.avg_luminance;
        w_p  = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (w_lf[i]) begin
                w_p = 5'(i);
            end
        end
        w_m0 = (w_p <= 5'd30) ? (w_lf << (5'd30 - w_p)) : (w_lf >> 1);
    end

    // datapath helpers
    logic [31:0]        w_sq;
    logic signed [31:0] w_t32;
    logic signed [31:0] w_tcl;
    logic signed [15:0] w_tc;
    logic [15:0]        w_rate;
    logic [43:0]        w_y;
    logic [23:0]        w_n;
    logic [19:0]        w_f;
    logic [4:0]         w_tidx;
    logic signed [16:0] w_d;
    logic [16:0]        w_mag;
    logic [63:0]        w_stepr;
    logic [16:0]        w_stepv;
    logic signed [16:0] w_e;
    logic signed [16:0] w_gn;
    logic signed [17:0] w_s;
    logic [17:0]        w_ns;
    logic [63:0]        w_up;
    logic [31:0]        w_gain;

    always_comb begin
        w_sq   = w_prod[61:30];
        w_t32  = (($signed({27'd0, r_p}) - 32'(LUM_FRAC_BITS)) <<< EV_FRAC_BITS)
               + $signed(32'(r_frac));
        // ceiling first, then floor; floor wins when the limits cross
        w_tcl  = (w_t32 > 32'(w_cfg.ev_ceiling)) ? 32'(w_cfg.ev_ceiling) : w_t32;
        if (w_tcl < 32'(w_cfg.ev_floor)) begin
            w_tc = w_cfg.ev_floor;
        end else begin
            w_tc = 16'(w_tcl);
        end
        w_rate  = (r_target > r_cur) ? w_cfg.rate_brighten : w_cfg.rate_darken;
        w_y     = 44'(w_prod >> 20);
        w_n     = w_y[43:20];
        w_f     = w_y[19:0];
        w_tidx  = 5'(r_cnt + 5'd1);
        w_d     = 17'(r_target) - 17'(r_cur);
        w_mag   = w_d[16] ? 17'(-w_d) : 17'(w_d);
        w_stepr = (w_prod + 64'(Q30_ONE >> 1)) >> 30;
        w_stepv = w_stepr[16:0];
        w_e     = w_cfg.auto_enable ? (17'(w_cfg.ev_compensation) - 17'(r_cur))
                                    : 17'(w_cfg.ev_compensation);
        // gain: floor integer part, exp2 of fraction shifted to Q16.16
        w_gn    = r_ge >>> EV_FRAC_BITS;
        w_s     = 18'(w_gn) - 18'sd14;
        w_ns    = 18'(-w_s);
        w_up    = 64'(r_m) << w_s[1:0];
        if (!w_s[17]) begin
            if (w_s > 18'sd2 || w_up > 64'hFFFF_FFFF) begin
                w_gain = 32'hFFFF_FFFF;
            end else begin
                w_gain = w_up[31:0];
            end
        end else if (w_ns >= 18'd40) begin
            w_gain = 32'd0;
        end else begin
            w_gain = 32'((64'(r_m) + (64'd1 << (w_ns[5:0] - 6'd1))) >> w_ns[5:0]);
        end
    end

    // multiplier operand select
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            S_LOG: begin
                w_ma = r_m;
                w_mb = r_m;
            end
            S_RATE: begin
                w_ma = 32'(w_rate);
                w_mb = 32'(r_dt);
            end
            S_LOGE: begin
                w_ma = r_x;
                w_mb = 32'(LOG2E_Q20);
            end
            S_EXP: begin
                w_ma = r_m;
                w_mb = POW_TAB[w_tidx];
            end
            S_STEP: begin
                w_ma = 32'(w_mag);
                w_mb = 32'(r_k);
            end
            default: ;
        endcase
    end

    assign i_in.ready          = (r_state == S_IDLE);
    assign o_out.valid         = r_out_valid;
    assign o_out.adapted_ev    = r_out_ev;
    assign o_out.exposure_gain = r_out_gain;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_first     <= 1'b1;
            r_cur       <= 16'sd0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_GOUT && (!r_out_valid || o_out.ready)) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_state <= S_LOG;
                    end
                end
                S_LOG: begin
                    if (r_cnt == EVF_LEN - 5'd1) begin
                        r_state <= S_CLAMP;
                    end
                end
                S_CLAMP: begin
                    if (r_first) begin
                        r_cur   <= w_tc;
                        r_first <= 1'b0;
                        r_state <= S_GSET;
                    end else begin
                        r_state <= S_RATE;
                    end
                end
                S_RATE: r_state <= S_LOGE;
                S_LOGE: begin
                    if (w_n >= 24'd31 || w_f == 20'd0) begin
                        r_state <= S_KCALC;
                    end else begin
                        r_state <= S_EXP;
                    end
                end
                S_EXP: begin
                    if (r_cnt == r_len - 5'd1) begin
                        r_state <= r_gain_ph ? S_GOUT : S_KCALC;
                    end
                end
                S_KCALC: r_state <= S_STEP;
                S_STEP: begin
                    r_cur   <= w_d[16] ? 16'(17'(r_cur) - w_stepv)
                                       : 16'(17'(r_cur) + w_stepv);
                    r_state <= S_GSET;
                end
                S_GSET: r_state <= S_EXP;
                S_GOUT: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_m    <= w_m0;
                r_p    <= w_p;
                r_dt   <= i_in.frame_time;
                r_frac <= '0;
                r_cnt  <= '0;
            end
            S_LOG: begin
                r_m    <= w_sq[31] ? {1'b0, w_sq[31:1]} : w_sq;
                r_frac <= {r_frac[EV_FRAC_BITS-2:0], w_sq[31]};
                r_cnt  <= r_cnt + 5'd1;
            end
            S_CLAMP: r_target <= w_tc;
            S_RATE:  r_x <= w_prod[31:0];
            S_LOGE: begin
                r_cnt     <= '0;
                r_len     <= EXP_LEN;
                r_gain_ph <= 1'b0;
                r_g       <= 20'(21'h10_0000 - 21'(w_f));
                if (w_n >= 24'd31) begin
                    r_m  <= '0;
                    r_sh <= '0;
                end else if (w_f == 20'd0) begin
                    r_m  <= Q30_ONE;
                    r_sh <= w_n[4:0];
                end else begin
                    r_m  <= Q30_ONE;
                    r_sh <= w_n[4:0] + 5'd1;
                end
            end
            S_EXP: begin
                if (r_g[5'd19 - r_cnt]) begin
                    r_m <= w_sq;
                end
                r_cnt <= r_cnt + 5'd1;
            end
            S_KCALC: r_k <= 31'(Q30_ONE - (r_m >> r_sh));
            S_GSET: begin
                r_ge      <= w_e;
                r_m       <= Q30_ONE;
                r_g       <= 20'(w_e[EV_FRAC_BITS-1:0]) << (20 - EV_FRAC_BITS);
                r_cnt     <= '0;
                r_len     <= EVF_LEN;
                r_gain_ph <= 1'b1;
            end
            S_GOUT: begin
                if (!r_out_valid || o_out.ready) begin
                    r_out_ev   <= r_cur;
                    r_out_gain <= w_gain;
                end
            end
            default: ;
        endcase
    end
endmodule

>>> verif/auto_exposure_adaptation_tb.sv
// Testbench: self-checking regression of auto_exposure_adaptation against a fixed-point predictor.
`timescale 1ns / 100ps

module auto_exposure_adaptation_tb
    import aea_pkg::*;
();

    localparam int EV_FB      = 10;
    localparam int LUM_FB     = 16;
    localparam int DRAIN_CYC  = 80;      // covers the worst-case result latency with margin
    localparam int CYCLE_CAP  = 1000000;
    localparam int PHASES     = 8;
    localparam int PHASE_LEN  = 230;
    localparam logic [2:0] CFG_SPARE_IDX = 3'd6;

    logic i_clk;
    logic i_rst_n;

    aea_in_if  in_ch ();
    aea_out_if out_ch ();
    aea_cfg_if cfg_ch ();

    auto_exposure_adaptation dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    // ---------------------------------------------------------------
    // Predictor state: register copy, adapted EV, first-frame flag
    // ---------------------------------------------------------------
    typedef struct {
        logic signed [15:0] ev;
        logic        [31:0] gain;
    } t_exposure_word;

    t_cfg               cfg_shadow;
    logic signed [15:0] ev_history;
    logic               snap_pending;
    logic [63:0]        root_tab [24];

    t_exposure_word     pending_results [$];
    int                 fail_count;
    int                 results_seen;
    int                 hold_cycles;     // long receiver hold-off, own process
    int                 cycle_count;

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] rem, res, b;
        rem = v;
        res = '0;
        b   = 64'd1 << 62;
        while (b > rem) b = b >> 2;
        while (b != 0) begin
            if (rem >= res + b) begin
                rem = rem - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // 2^(f / 2^nbits) in Q1.30, bit by bit through the root table
    function automatic logic [63:0] pow2_frac(input logic [31:0] f, input int nbits);
        logic [63:0] r;
        r = 64'd1 << 30;
        for (int i = 1; i <= nbits; i++)
            if (f[nbits-i]) r = (r * root_tab[i]) >> 30;
        return r;
    endfunction

    function automatic int lum_to_ev(input logic [31:0] lum_in);
        logic [31:0] lum;
        logic [63:0] m;
        int          p, frac;
        lum  = (lum_in < 32'd7) ? 32'd7 : lum_in;    // ~0.0001 floor
        p    = 31;
        frac = 0;
        while (p > 0 && !lum[p]) p--;
        m = (p <= 30) ? (64'(lum) << (30 - p)) : (64'(lum) >> 1);
        for (int i = 0; i < EV_FB; i++) begin
            m    = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd2 << 30)) begin
                frac = frac | 1;
                m    = m >> 1;
            end
        end
        return (p - LUM_FB) * (1 << EV_FB) + frac;
    endfunction

    // 1 - exp(-rate*dt) in Q0.30
    function automatic logic [63:0] blend_factor(input logic [15:0] rate, input logic [15:0] dt);
        logic [63:0] x, y, n, e;
        logic [31:0] f;
        x = 64'(rate) * 64'(dt);
        y = (x * 64'd1512775) >> 20;
        n = y >> 20;
        f = 32'(y[19:0]);
        if (n >= 31)      e = 0;
        else if (f == 0)  e = (64'd1 << 30) >> n;
        else              e = pow2_frac((32'd1 << 20) - f, 20) >> (n + 1);
        return (64'd1 << 30) - e;
    endfunction

    function automatic logic [31:0] ev_to_gain(input int e);
        int          n, s;
        logic [63:0] m;
        n = e >>> EV_FB;                          // floor division
        m = pow2_frac(32'(e - (n << EV_FB)), EV_FB);
        s = n - 14;
        if (s >= 0) begin
            if (s > 2) return 32'hFFFF_FFFF;
            m = m << s;
            return (m > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : m[31:0];
        end
        s = -s;
        if (s >= 40) return 32'd0;
        return 32'((m + (64'd1 << (s - 1))) >> s);
    endfunction

    function automatic t_exposure_word predict_exposure(input logic [31:0] lum,
                                                        input logic [15:0] dt);
        t_exposure_word w;
        int             target, cur, d, stepv, e;
        logic [63:0]    k, mag;
        target = lum_to_ev(lum);
        if (target > int'(cfg_shadow.ev_ceiling)) target = cfg_shadow.ev_ceiling;
        if (target < int'(cfg_shadow.ev_floor))   target = cfg_shadow.ev_floor;
        cur = ev_history;
        if (snap_pending) begin
            cur          = target;
            snap_pending = 1'b0;
        end else begin
            k     = blend_factor((target > cur) ? cfg_shadow.rate_brighten
                                                : cfg_shadow.rate_darken, dt);
            d     = target - cur;
            mag   = 64'((d < 0) ? -d : d);
            stepv = int'((mag * k + (64'd1 << 29)) >> 30);
            cur   = (d < 0) ? cur - stepv : cur + stepv;
        end
        ev_history = 16'(cur);
        e = cfg_shadow.auto_enable ? (int'(cfg_shadow.ev_compensation) - cur)
                                   : int'(cfg_shadow.ev_compensation);
        w.ev   = 16'(cur);
        w.gain = ev_to_gain(e);
        return w;
    endfunction

    // ---------------------------------------------------------------
    // Directed rows; a write row changes one register before its word
    // ---------------------------------------------------------------
    typedef struct {
        bit                 wr;
        logic [2:0]         idx;
        logic [15:0]        dat;
        logic [31:0]        lum;
        logic [15:0]        dt;
        bit                 typed;
        logic signed [15:0] ev;
        logic        [31:0] gain;
    } t_stim_row;

    t_stim_row stim_rows [] = '{
        // first frame snaps to log2(1.0) = 0, gain 1.0
        '{0, 0, 0, 32'h0001_0000, 16'h0000, 1, 16'sd0, 32'h0001_0000},
        // zero frame time: EV holds
        '{0, 0, 0, 32'hFFFF_FFFF, 16'h0000, 1, 16'sd0, 32'h0001_0000},
        '{0, 0, 0, 32'h0000_0000, 16'hFFFF, 0, 0, 0},
        '{0, 0, 0, 32'hFFFF_FFFF, 16'hFFFF, 0, 0, 0},
        '{0, 0, 0, 32'h0000_0001, 16'h1000, 0, 0, 0},
        '{0, 0, 0, 32'h0000_0007, 16'h0800, 0, 0, 0},
        '{0, 0, 0, 32'h0000_0008, 16'h0001, 0, 0, 0},
        '{0, 0, 0, 32'h8000_0000, 16'h0100, 0, 0, 0},
        '{0, 0, 0, 32'h0001_8000, 16'h4000, 0, 0, 0},
        // zero brighten rate: no upward move
        '{1, CFG_RATE_BRT, 16'h0000, 32'hFFFF_0000, 16'hFFFF, 0, 0, 0},
        '{1, CFG_RATE_DRK, 16'hFFFF, 32'h0000_0010, 16'h0001, 0, 0, 0},
        '{1, CFG_RATE_BRT, 16'hFFFF, 32'h7FFF_FFFF, 16'hFFFF, 0, 0, 0},
        // crossed limits: target pinned to the floor
        '{1, CFG_EV_FLOOR, 16'h0800, 32'h0000_0100, 16'h1000, 0, 0, 0},
        '{1, CFG_EV_CEILING, 16'hF800, 32'hFFFF_FFFF, 16'h1000, 0, 0, 0},
        '{1, CFG_EV_FLOOR, 16'h8000, 32'h0000_0002, 16'h2000, 0, 0, 0},
        '{1, CFG_EV_CEILING, 16'h7FFF, 32'hF000_0000, 16'h0300, 0, 0, 0},
        '{1, CFG_EV_COMP, 16'h7FFF, 32'h0000_0003, 16'h0FFF, 0, 0, 0},
        '{1, CFG_EV_COMP, 16'h8000, 32'h0400_0000, 16'h0FFF, 0, 0, 0},
        // auto off: gain from compensation only, saturating both ends
        '{1, CFG_AUTO_EN, 16'h0000, 32'h0001_0000, 16'h1000, 1, 16'sd0, 32'h0000_0000},
        '{1, CFG_EV_COMP, 16'h7FFF, 32'h0001_0000, 16'h0000, 1, 16'sd0, 32'hFFFF_FFFF},
        '{1, CFG_EV_COMP, 16'h0000, 32'h0002_0000, 16'h0000, 0, 0, 0},
        // index beyond the register map is dropped
        '{1, CFG_SPARE_IDX, 16'h1234, 32'h0010_0000, 16'h0400, 0, 0, 0},
        '{1, CFG_AUTO_EN, 16'hFFFF, 32'h0000_4000, 16'h0800, 0, 0, 0}
    };

    // ---------------------------------------------------------------
    // Clock, reset, cycle cap
    // ---------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("auto_exposure_adaptation regression: fail");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Result side: random stall per word, plus one long hold-off
    // ---------------------------------------------------------------
    int stall_left;
    int seen_last;

    always @(negedge i_clk) begin
        int draw;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_left   <= $urandom_range(0, 5);
            seen_last    <= 0;
        end else if (results_seen != seen_last) begin
            draw         = $urandom_range(0, 5);
            seen_last    <= results_seen;
            stall_left   <= (draw > 0) ? draw - 1 : 0;
            out_ch.ready <= (draw == 0) && (hold_cycles == 0);
        end else if (hold_cycles > 0 || stall_left > 0) begin
            out_ch.ready <= 1'b0;
            if (stall_left > 0) stall_left <= stall_left - 1;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // word-level checker
    always @(posedge i_clk) begin
        t_exposure_word w;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            results_seen <= results_seen + 1;
            if (pending_results.size() == 0) begin
                $error("unexpected result word: adapted_ev %0d exposure_gain %h",
                       out_ch.adapted_ev, out_ch.exposure_gain);
                fail_count++;
            end else begin
                w = pending_results.pop_front();
                if (out_ch.adapted_ev !== w.ev) begin
                    $error("adapted_ev expected %0d actual %0d", w.ev, out_ch.adapted_ev);
                    fail_count++;
                end
                if (out_ch.exposure_gain !== w.gain) begin
                    $error("exposure_gain expected %h actual %h", w.gain, out_ch.exposure_gain);
                    fail_count++;
                end
            end
        end
    end

    // long hold-off so the result register fills and input stalls
    initial begin
        hold_cycles = 0;
        wait (results_seen >= 300);
        @(negedge i_clk);
        hold_cycles = 400;
        while (hold_cycles > 0) begin
            @(posedge i_clk);
            hold_cycles = hold_cycles - 1;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus side
    // ---------------------------------------------------------------
    task automatic send_word(input logic [31:0] lum, input logic [15:0] dt,
                             input bit typed, input t_exposure_word typed_word);
        int             gap;
        t_exposure_word w;
        gap = $urandom_range(0, 5);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.avg_luminance <= lum;
        in_ch.frame_time    <= dt;
        in_ch.valid         <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (in_ch.ready) break;
        end
        w = predict_exposure(lum, dt);
        pending_results.push_back(typed ? typed_word : w);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] dat);
        @(negedge i_clk);
        cfg_ch.index <= idx;
        cfg_ch.data  <= dat;
        cfg_ch.valid <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (cfg_ch.ready) break;
        end
        case (idx)
            CFG_EV_FLOOR:   cfg_shadow.ev_floor        = dat;
            CFG_EV_CEILING: cfg_shadow.ev_ceiling      = dat;
            CFG_RATE_BRT:   cfg_shadow.rate_brighten   = dat;
            CFG_RATE_DRK:   cfg_shadow.rate_darken     = dat;
            CFG_EV_COMP:    cfg_shadow.ev_compensation = dat;
            CFG_AUTO_EN:    cfg_shadow.auto_enable     = dat[0];
            default: ;
        endcase
    endtask

    // let every outstanding word come back, then allow for trailing work
    task automatic drain();
        @(negedge i_clk);
        in_ch.valid  <= 1'b0;
        cfg_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_lum();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 15);
            1:       return 32'hFFFF_FFFF - $urandom_range(0, 15);
            2, 3:    return 32'h0001_0000 + $urandom_range(0, 32'h3_0000);
            4, 5, 6: return $urandom >> $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] rand_dt();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2, 3, 4: return 16'($urandom_range(0, 16'h0400));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_reg16();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        t_exposure_word tw;
        logic [15:0]    lo, hi;
        cycle_count          = 0;
        fail_count           = 0;
        results_seen         = 0;
        in_ch.valid          = 1'b0;
        in_ch.avg_luminance  = '0;
        in_ch.frame_time     = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = '0;
        cfg_ch.data          = '0;
        for (int i = 0; i < 24; i++)
            root_tab[i] = (i == 0) ? (64'd2 << 30) : int_sqrt(root_tab[i-1] << 30);
        cfg_shadow.ev_floor        = -16'sd8192;
        cfg_shadow.ev_ceiling      = 16'sd16384;
        cfg_shadow.rate_brighten   = 16'd256;
        cfg_shadow.rate_darken     = 16'd256;
        cfg_shadow.ev_compensation = 16'sd0;
        cfg_shadow.auto_enable     = 1'b1;
        ev_history   = '0;
        snap_pending = 1'b1;

        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed rows
        foreach (stim_rows[r]) begin
            if (stim_rows[r].wr) begin
                drain();
                write_reg(stim_rows[r].idx, stim_rows[r].dat);
            end
            tw.ev   = stim_rows[r].ev;
            tw.gain = stim_rows[r].gain;
            send_word(stim_rows[r].lum, stim_rows[r].dt, stim_rows[r].typed, tw);
        end

        // random phases, each under a fresh register setting
        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            case (ph)
                0:       begin lo = 16'h8000; hi = 16'h7FFF; end   // widest range
                1:       begin lo = 16'h1000; hi = 16'hF000; end   // crossed
                2:       begin lo = 16'hE000; hi = 16'h6000; end   // near reset values
                default: begin lo = rand_reg16(); hi = rand_reg16(); end
            endcase
            write_reg(CFG_EV_FLOOR, lo);
            write_reg(CFG_EV_CEILING, hi);
            write_reg(CFG_RATE_BRT, (ph == 1) ? 16'h0000 : rand_reg16());
            write_reg(CFG_RATE_DRK, (ph == 2) ? 16'hFFFF : rand_reg16());
            write_reg(CFG_EV_COMP, rand_reg16());
            write_reg(CFG_AUTO_EN, (ph == 3) ? 16'h0000 : 16'($urandom_range(0, 3) != 0));
            write_reg(3'($urandom_range(6, 7)), 16'($urandom));
            for (int n = 0; n < PHASE_LEN; n++)
                send_word(rand_lum(), rand_dt(), 1'b0, tw);
        end

        drain();
        if (fail_count == 0) begin
            $display("auto_exposure_adaptation regression: pass");
        end else begin
            $display("auto_exposure_adaptation regression: fail");
        end
        $finish;
    end

endmodule

>>> auto_exposure_adaptation.f
rtl/aea_pkg.sv
rtl/aea_in_if.sv
rtl/aea_out_if.sv
rtl/aea_cfg_if.sv
rtl/aea_mul.sv
rtl/aea_cfg.sv
rtl/auto_exposure_adaptation.sv
verif/auto_exposure_adaptation_tb.sv
